### rtl/sdss_pkg.sv
package sdss_pkg;

  localparam int MaxSegments = 256;
  localparam int SegIdxW     = $clog2(MaxSegments);
  localparam int SegCntW     = $clog2(MaxSegments + 1);
  localparam int CoordInW    = 7;
  localparam int CoordW      = 12;
  localparam int PosW        = 10;
  localparam int CostW       = 27;
  localparam int StepW       = 6;
  localparam int PassW       = 8;
  localparam int CfgIdxW     = 1;
  localparam int CfgDataW    = 8;
  localparam int CoordMax    = 100;
  localparam int Scale       = 10;
  localparam int D2W         = 22;
  localparam int RadW        = D2W + 16;
  localparam int RootW       = RadW / 2;
  localparam int SumW        = CostW + SegIdxW + 2;
  localparam logic [CostW-1:0] CostMax = '1;

  localparam logic [CfgIdxW-1:0] CfgStartStep = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgPasses    = 1'b1;

  typedef struct packed {
    logic            vertical;
    logic [PosW-1:0] ax;
    logic [PosW-1:0] ay;
    logic [PosW-1:0] bx;
    logic [PosW-1:0] by;
  } seg_t;

  localparam int SegW = $bits(seg_t);

  typedef enum logic [3:0] {
    ST_IDLE, ST_INIT, ST_RD, ST_SEL, ST_SQ, ST_ROOT, ST_ACC, ST_EVAL, ST_NEXT, ST_OUT
  } state_e;

  function automatic logic [PosW-1:0] load_coord(input logic [CoordInW-1:0] v);
    logic [CoordInW-1:0] c;
    c = (v > CoordInW'(CoordMax)) ? CoordInW'(CoordMax) : v;
    return PosW'(c) * PosW'(Scale);
  endfunction

endpackage

### rtl/sdss_ram.sv
module sdss_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

### rtl/sdss_sqrt.sv
module sdss_sqrt (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  logic [sdss_pkg::RadW-1:0] rad_i,
  output logic done_o,
  output logic [sdss_pkg::RootW-1:0] root_o
);
  import sdss_pkg::*;

  localparam int CntW = $clog2(RootW + 1);

  logic [RadW-1:0]  rad_q, rad_d;
  logic [RootW+1:0] rem_q, rem_d;
  logic [RootW-1:0] root_q, root_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic [RootW+1:0] trial;

  // one result bit per cycle, restoring
  always_comb begin
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = '0;
    if (start_i) begin
      rad_d  = rad_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = CntW'(RootW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = {rem_q[RootW-1:0], rad_q[RadW-1 -: 2]};
      rad_d = {rad_q[RadW-3:0], 2'b00};
      trial = {root_q, 2'b01};
      if (rem_d >= trial) begin
        rem_d  = rem_d - trial;
        root_d = {root_q[RootW-2:0], 1'b1};
      end else begin
        root_d = {root_q[RootW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = busy_q && (cnt_q == CntW'(1));
  assign root_o = root_d;
endmodule

### rtl/segment_distance_sum_search.sv
// channel | dir | fields (lsb first)
// s_axis  | in  | tuser: operation; tdata: x_start, y_start, x_end, y_end
// m_axis  | out | tdata: best_x, best_y, total_distance
// cfg     | in  | index 0 start_step, 1 passes_per_step
// A solve evaluates 1 + 4*start_step*passes candidate points; each passes
// through INIT, then per stored segment RD, SEL and ACC for a perpendicular
// gap, with SQ and ROOT added for an endpoint distance through the shared
// bit-serial square root unit, then EVAL and NEXT. Result is registered.
// Reset is async active low; store contents are not cleared.
// Input stalls during a solve; output holds until m_axis_tready.
module segment_distance_sum_search (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // x_start, y_start, x_end, y_end
  input  logic        s_axis_tuser,  // operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // best_x, best_y, total_distance
  input  logic        cfg_we_i,
  input  logic [sdss_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [sdss_pkg::CfgDataW-1:0] cfg_data_i
);
  import sdss_pkg::*;

  state_e state_q, state_d;
  logic [StepW-1:0]   start_step_q;
  logic [PassW-1:0]   passes_q;
  logic [SegCntW-1:0] count_q, count_d;
  logic [SegIdxW-1:0] idx_q, idx_d;
  logic [PosW-1:0]    cx_q, cx_d, cy_q, cy_d;
  logic [CostW-1:0]   best_q, best_d;
  logic [StepW-1:0]   step_q, step_d;
  logic [PassW-1:0]   pass_q, pass_d;
  logic [1:0]         dir_q, dir_d;
  logic               first_q, first_d;
  logic [SumW-1:0]    sum_q, sum_d;
  logic signed [CoordW-1:0] nx_q, nx_d, ny_q, ny_d;
  logic signed [CoordW-1:0] dx_q, dx_d, dy_q, dy_d;
  logic               perp_q, perp_d;
  logic [D2W-1:0]     d2_q, d2_d;
  logic               sq_start;
  logic               sq_done;
  logic [RootW-1:0]   root;
  logic [PosW-1:0]    res_x_q, res_y_q;
  logic [CostW-1:0]   res_c_q;
  logic               load_fire;
  seg_t               wseg, rseg;
  logic [PosW-1:0]    x0, y0, x1, y1;
  logic               vert, swap;
  logic [CostW-1:0]   sat;
  logic signed [CoordW-1:0] ax, ay, bx, by;
  logic [StepW-1:0]   tstep;
  logic               done_now;

  assign x0 = load_coord(s_axis_tdata[6:0]);
  assign y0 = load_coord(s_axis_tdata[13:7]);
  assign x1 = load_coord(s_axis_tdata[20:14]);
  assign y1 = load_coord(s_axis_tdata[27:21]);
  assign vert = (x0 == x1);
  assign swap = vert ? (y0 > y1) : (x0 > x1);
  always_comb begin
    wseg.vertical = vert;
    wseg.ax = swap ? x1 : x0;
    wseg.ay = swap ? y1 : y0;
    wseg.bx = swap ? x0 : x1;
    wseg.by = swap ? y0 : y1;
  end

  assign s_axis_tready = (state_q == ST_IDLE) && !m_axis_tvalid;
  assign load_fire = s_axis_tvalid && s_axis_tready && !s_axis_tuser
                     && (count_q < SegCntW'(MaxSegments));

  sdss_ram #(.Width(SegW), .Depth(MaxSegments)) u_ram (
    .clk_i, .we_i(load_fire), .waddr_i(count_q[SegIdxW-1:0]),
    .wdata_i(wseg), .raddr_i(idx_q), .rdata_o(rseg)
  );

  sdss_sqrt u_sqrt (
    .clk_i, .rst_ni, .start_i(sq_start),
    .rad_i({d2_d, 16'd0}), .done_o(sq_done), .root_o(root)
  );

  assign sat = (sum_q > SumW'(CostMax)) ? CostMax : sum_q[CostW-1:0];
  assign ax = CoordW'(rseg.ax);
  assign ay = CoordW'(rseg.ay);
  assign bx = CoordW'(rseg.bx);
  assign by = CoordW'(rseg.by);

  assign done_now =
    (first_q && (step_q == '0 || passes_q == '0)) ||
    (!first_q && dir_q == 2'd3 && pass_q + 1'b1 == passes_q && step_q == StepW'(1));
  assign tstep = step_d - 1'b1;

  always_comb begin
    unique case (state_q)
      ST_IDLE: state_d = (s_axis_tvalid && s_axis_tready && s_axis_tuser)
                         ? ((count_q == '0) ? ST_OUT : ST_INIT) : ST_IDLE;
      ST_INIT: state_d = ST_RD;
      ST_RD:   state_d = ST_SEL;
      ST_SEL:  state_d = perp_d ? ST_ACC : ST_SQ;
      ST_SQ:   state_d = ST_ROOT;
      ST_ROOT: state_d = sq_done ? ST_ACC : ST_ROOT;
      ST_ACC:  state_d = (SegCntW'(idx_q) + 1'b1 == count_q) ? ST_EVAL : ST_RD;
      ST_EVAL: state_d = ST_NEXT;
      ST_NEXT: state_d = done_now ? ST_OUT : ST_INIT;
      ST_OUT:  state_d = m_axis_tvalid ? ST_OUT : ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    count_d = count_q; idx_d = idx_q; cx_d = cx_q; cy_d = cy_q;
    best_d = best_q; step_d = step_q; pass_d = pass_q; dir_d = dir_q;
    first_d = first_q; sum_d = sum_q; nx_d = nx_q; ny_d = ny_q;
    dx_d = dx_q; dy_d = dy_q; perp_d = perp_q; d2_d = d2_q;
    sq_start = 1'b0;
    if (load_fire) count_d = count_q + 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid && s_axis_tready && s_axis_tuser) begin
          cx_d = '0; cy_d = '0; best_d = '0; first_d = 1'b1;
          step_d = start_step_q; pass_d = '0; dir_d = '0;
          nx_d = '0; ny_d = '0;
        end
      end
      ST_INIT: begin
        idx_d = '0; sum_d = '0;
      end
      ST_RD: ;
      ST_SEL: begin
        perp_d = 1'b0;
        if (rseg.vertical) begin
          if (ny_q >= by) begin dx_d = nx_q - bx; dy_d = ny_q - by; end
          else if (ny_q <= ay) begin dx_d = nx_q - ax; dy_d = ny_q - ay; end
          else begin perp_d = 1'b1; dx_d = nx_q - bx; dy_d = '0; end
        end else begin
          if (nx_q >= bx) begin dx_d = nx_q - bx; dy_d = ny_q - by; end
          else if (nx_q <= ax) begin dx_d = nx_q - ax; dy_d = ny_q - ay; end
          else begin perp_d = 1'b1; dx_d = '0; dy_d = ny_q - by; end
        end
      end
      ST_SQ: begin
        d2_d = D2W'(D2W'(dx_q) * D2W'(dx_q) + D2W'(dy_q) * D2W'(dy_q));
        sq_start = 1'b1;
      end
      ST_ROOT: ;
      ST_ACC: begin
        if (perp_q) begin
          sum_d = sum_q + SumW'({(dx_q[CoordW-1] ? -dx_q : dx_q) |
                                 (dy_q[CoordW-1] ? -dy_q : dy_q), 8'd0});
        end else begin
          sum_d = sum_q + SumW'(root);
        end
        idx_d = idx_q + 1'b1;
      end
      ST_EVAL: begin
        if (first_q || (sat < best_q)) begin
          best_d = sat; cx_d = nx_q[PosW-1:0]; cy_d = ny_q[PosW-1:0];
        end
      end
      ST_NEXT: begin
        if (!first_q) begin
          dir_d = dir_q + 1'b1;
          if (dir_q == 2'd3) begin
            pass_d = pass_q + 1'b1;
            if (pass_q + 1'b1 == passes_q) begin
              pass_d = '0; step_d = step_q - 1'b1;
            end
          end
        end
        first_d = 1'b0;
        // candidate point for the next evaluation
        case (dir_d)
          2'd0: begin nx_d = CoordW'(cx_q); ny_d = CoordW'(cy_q) + CoordW'(tstep); end
          2'd1: begin nx_d = CoordW'(cx_q) + CoordW'(tstep); ny_d = CoordW'(cy_q); end
          2'd2: begin nx_d = CoordW'(cx_q); ny_d = CoordW'(cy_q) - CoordW'(tstep); end
          default: begin nx_d = CoordW'(cx_q) - CoordW'(tstep); ny_d = CoordW'(cy_q); end
        endcase
      end
      ST_OUT: ;
      default: ;
    endcase
    if (state_q == ST_OUT && !m_axis_tvalid) count_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; start_step_q <= StepW'(40); passes_q <= PassW'(200);
      count_q <= '0; m_axis_tvalid <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgStartStep: start_step_q <= cfg_data_i[StepW-1:0];
          CfgPasses:    passes_q <= cfg_data_i[PassW-1:0];
          default: ;
        endcase
      end
      if (state_q == ST_OUT && !m_axis_tvalid) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d; cx_q <= cx_d; cy_q <= cy_d; best_q <= best_d;
    step_q <= step_d; pass_q <= pass_d; dir_q <= dir_d; first_q <= first_d;
    sum_q <= sum_d; dx_q <= dx_d; dy_q <= dy_d; perp_q <= perp_d; d2_q <= d2_d;
    nx_q <= nx_d; ny_q <= ny_d;
    if (state_q == ST_OUT && !m_axis_tvalid) begin
      res_x_q <= cx_q; res_y_q <= cy_q;
      res_c_q <= (count_q == '0) ? '0 : best_q;
    end
  end

  assign m_axis_tdata = {1'b0, res_c_q, res_y_q, res_x_q};
  logic unused;
  assign unused = ^s_axis_tdata[31:28];
endmodule
